### rtl/g2p_pkg.sv
// Package for the Gregorian to Persian date converter.
// Holds the payload structs, the calendar constants and the month table.
// No dependencies; every other file in rtl uses it by scoped names.
`timescale 1ns / 1ps

package g2p_pkg;

    typedef struct packed {
        logic [11:0] greg_year;
        logic [3:0]  greg_month;
        logic [4:0]  greg_day;
    } greg_date_t;

    typedef struct packed {
        logic [11:0] persian_year;
        logic [3:0]  persian_month;
        logic [4:0]  persian_day;
    } persian_date_t;

    // Persian year and the day of that year, handed from the year fold to the month split.
    typedef struct packed {
        logic [11:0] persian_year;
        logic [8:0]  day_of_year;
    } year_pos_t;

    localparam logic [11:0] YEAR_OFFSET     = 12'd622;
    localparam logic [9:0]  DAYS_COMMON     = 10'd365;
    localparam logic [9:0]  DAYS_LEAP       = 10'd366;
    localparam logic [9:0]  NOWRUZ_OFFSET   = 10'd80;
    localparam logic [8:0]  FIRST_HALF_END  = 9'd186;
    localparam logic [8:0]  ELEVENTH_END    = 9'd336;
    localparam logic [3:0]  MONTH_JAN       = 4'd1;
    localparam logic [3:0]  MONTH_MAR       = 4'd3;
    localparam logic [3:0]  MONTH_DEC       = 4'd12;
    localparam logic [3:0]  MONTH_SEVENTH   = 4'd7;
    localparam logic [3:0]  MONTH_LAST      = 4'd12;

    // Days in the Gregorian year before the first of the given month.
    function automatic logic [8:0] cum_days(input logic [3:0] month);
        logic [8:0] days;
        unique case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

### rtl/g2p_year_fold.sv
// Year fold: Gregorian date to Persian year and day of the Persian year.
// Purely combinational; depends on g2p_pkg.
`timescale 1ns / 1ps

module g2p_year_fold (
    input  g2p_pkg::greg_date_t date,
    output g2p_pkg::year_pos_t  pos
);

    logic       g_leap;
    logic       prev_leap;
    logic       month_ok;
    logic [9:0] base_days;
    logic [9:0] year_len;
    logic [9:0] count;
    logic [11:0] year_base;

    assign g_leap    = (date.greg_year[1:0] == 2'd0);
    // The year before is leap exactly when this year is 1 mod 4, and so is the Persian year.
    assign prev_leap = (date.greg_year[1:0] == 2'd1);
    assign month_ok  = (date.greg_month >= g2p_pkg::MONTH_JAN)
                    && (date.greg_month <= g2p_pkg::MONTH_DEC);
    assign year_len  = prev_leap ? g2p_pkg::DAYS_LEAP : g2p_pkg::DAYS_COMMON;

    always_comb
    begin
        base_days = month_ok
            ? ({5'd0, date.greg_day} + {1'b0, g2p_pkg::cum_days(date.greg_month)})
            : 10'd0;
        count = base_days + 10'd1
              + {9'd0, (g_leap && (date.greg_month >= g2p_pkg::MONTH_MAR))}
              + (year_len - g2p_pkg::NOWRUZ_OFFSET);
        year_base = date.greg_year - g2p_pkg::YEAR_OFFSET;
        if (count > year_len)
        begin
            pos.persian_year = year_base + 12'd1;
            pos.day_of_year  = 9'(count - year_len);
        end
        else
        begin
            pos.persian_year = year_base;
            pos.day_of_year  = count[8:0];
        end
    end

endmodule

### rtl/g2p_month_split.sv
// Month split: day of the Persian year to month and day of month.
// Purely combinational; depends on g2p_pkg.
`timescale 1ns / 1ps

module g2p_month_split (
    input  logic [8:0] day_of_year,
    output logic [3:0] persian_month,
    output logic [4:0] persian_day
);

    logic [8:0] rest;
    logic [2:0] idx;

    always_comb
    begin
        idx  = 3'd0;
        rest = 9'd0;
        if (day_of_year <= g2p_pkg::FIRST_HALF_END)
        begin
            // Months of 31 days: count the whole months already gone.
            for (int k = 1; k <= 5; k++)
            begin
                if (day_of_year > 9'(31 * k))
                begin
                    idx = idx + 3'd1;
                end
            end
            rest          = day_of_year - 9'(31 * idx);
            persian_month = g2p_pkg::MONTH_JAN + {1'b0, idx};
            persian_day   = rest[4:0];
        end
        else if (day_of_year <= g2p_pkg::ELEVENTH_END)
        begin
            rest = day_of_year - g2p_pkg::FIRST_HALF_END;
            for (int k = 1; k <= 4; k++)
            begin
                if (rest > 9'(30 * k))
                begin
                    idx = idx + 3'd1;
                end
            end
            rest          = rest - 9'(30 * idx);
            persian_month = g2p_pkg::MONTH_SEVENTH + {1'b0, idx};
            persian_day   = rest[4:0];
        end
        else
        begin
            // The last month runs from day 337 whether the year is leap or not.
            rest          = day_of_year - g2p_pkg::ELEVENTH_END;
            persian_month = g2p_pkg::MONTH_LAST;
            persian_day   = rest[4:0];
        end
    end

endmodule

### rtl/gregorian_to_persian_date_core.sv
// Gregorian to Persian date converter, top level.
// Uses g2p_pkg, g2p_year_fold and g2p_month_split.
//
//   channel   direction  handshake                      payload
//   greg      in         greg_valid / greg_ready        greg_date (greg_date_t)
//   persian   out        persian_valid / persian_ready  persian_date (persian_date_t)
//
// One date is taken per cycle while greg_ready is high; its result passes the input register
// and then the result register, and it leaves once persian_ready takes it.
// The conversion sits between the input register and the result register.
// Reset empties both registers; no payload is cleared.
// A stalled result holds the pipeline only as far as needed: the input register still
// takes a new date while the result register waits, if it is empty.
`timescale 1ns / 1ps

module gregorian_to_persian_date_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   greg_valid,
    output logic                   greg_ready,
    input  g2p_pkg::greg_date_t    greg_date,
    output logic                   persian_valid,
    input  logic                   persian_ready,
    output g2p_pkg::persian_date_t persian_date
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    g2p_pkg::greg_date_t    in_data_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    g2p_pkg::persian_date_t out_data_reg;
    g2p_pkg::persian_date_t out_data_next;
    g2p_pkg::year_pos_t     pos;
    logic [3:0]             split_month;
    logic [4:0]             split_day;
    logic                   out_advance;

    assign out_advance = !out_valid_reg || persian_ready;
    assign greg_ready  = !in_valid_reg || out_advance;

    g2p_year_fold u_year_fold (
        .date (in_data_reg),
        .pos  (pos)
    );

    g2p_month_split u_month_split (
        .day_of_year   (pos.day_of_year),
        .persian_month (split_month),
        .persian_day   (split_day)
    );

    always_comb
    begin
        out_data_next.persian_year  = pos.persian_year;
        out_data_next.persian_month = split_month;
        out_data_next.persian_day   = split_day;
        in_valid_next  = greg_ready ? greg_valid : in_valid_reg;
        out_valid_next = out_advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (greg_valid && greg_ready)
        begin
            in_data_reg <= greg_date;
        end
        if (in_valid_reg && out_advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign persian_valid = out_valid_reg;
    assign persian_date  = out_data_reg;

endmodule

### rtl/g2p_checker.sv
// Port checker for the Gregorian to Persian date converter, bound to the top level.
// Watches the ports only; depends on g2p_pkg.
`timescale 1ns / 1ps

module g2p_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   greg_valid,
    input logic                   greg_ready,
    input logic                   persian_valid,
    input logic                   persian_ready,
    input g2p_pkg::persian_date_t persian_date
);

    // A result waiting for the sink keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        persian_valid && !persian_ready |=> persian_valid && $stable(persian_date))
    else $error("result changed or vanished while stalled");

    // An accepted date followed by a ready sink leaves a valid result in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (greg_valid && greg_ready) ##1 persian_ready |=> persian_valid)
    else $error("accepted date produced no result in time");

    // Month always lies in 1..12 and day is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        persian_valid |-> (persian_date.persian_month >= 4'd1)
                       && (persian_date.persian_month <= 4'd12)
                       && (persian_date.persian_day != 5'd0))
    else $error("result month or day out of range");

    // Months seven to twelve have at most thirty days.
    assert property (@(posedge clk) disable iff (!rst_n)
        persian_valid && (persian_date.persian_month >= 4'd7)
            |-> (persian_date.persian_day <= 5'd30))
    else $error("day too large for a thirty-day month");

endmodule

bind gregorian_to_persian_date_core g2p_checker u_g2p_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .greg_valid    (greg_valid),
    .greg_ready    (greg_ready),
    .persian_valid (persian_valid),
    .persian_ready (persian_ready),
    .persian_date  (persian_date)
);

### tb/sv/tb_gregorian_to_persian_date_core.sv
// Self-checking testbench for gregorian_to_persian_date_core.
// It drives Gregorian dates, predicts each Persian date and checks the results in order.
// It depends on g2p_pkg and on the RTL of gregorian_to_persian_date_core.
`timescale 1ns / 1ps

module tb_gregorian_to_persian_date_core;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 3;
    localparam int RANDOM_DATES   = 500;
    localparam int HOLD_AT        = 100;
    localparam int HOLD_BURST     = 40;
    localparam int QUIET_FROM     = 420;
    localparam int LONG_HOLD      = 60;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RUN_LIMIT_NS   = 2_000_000;

    // Calendar figures for the Persian year and its split into months.
    localparam int NOWRUZ_SHIFT   = 80;
    localparam int FIRST_HALF_END = 186;
    localparam int ELEVENTH_END   = 336;

    class date_scoreboard;
        g2p_pkg::persian_date_t awaited[$];
        int unsigned            errors;

        function new();
            errors = 0;
        endfunction

        static function g2p_pkg::persian_date_t to_persian(g2p_pkg::greg_date_t g);
            int                     month_start [12];
            int                     yr_mod;
            int                     year_len;
            int                     n;
            int                     pm;
            int                     pd;
            bit                     leap_g;
            bit                     leap_p;
            logic [11:0]            py;
            g2p_pkg::persian_date_t r;
            month_start = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
            yr_mod   = int'(g.greg_year) % 4;
            leap_g   = (yr_mod == 0);
            // A year that is 1 mod 4 follows a leap year and is itself a leap Persian year.
            leap_p   = (yr_mod == 1);
            year_len = leap_p ? 366 : 365;
            py       = g.greg_year - 12'd622;
            n = 0;
            if (g.greg_month >= 4'd1 && g.greg_month <= 4'd12)
                n = int'(g.greg_day) + month_start[int'(g.greg_month) - 1];
            n += 1;
            if (leap_g && g.greg_month >= 4'd3)
                n += 1;
            n += year_len - NOWRUZ_SHIFT;
            if (n > year_len)
            begin
                py += 12'd1;
                n  -= year_len;
            end
            if (n <= FIRST_HALF_END)
            begin
                pm = n / 31 + 1;
                pd = n % 31;
                if (pd == 0)
                begin
                    pd = 31;
                    pm -= 1;
                end
            end
            else if (n <= ELEVENTH_END)
            begin
                n -= FIRST_HALF_END;
                pm = n / 30 + 7;
                pd = n % 30;
                if (pd == 0)
                begin
                    pd = 30;
                    pm -= 1;
                end
            end
            else
            begin
                pm = 12;
                pd = n - ELEVENTH_END;
            end
            r.persian_year  = py;
            r.persian_month = 4'(pm);
            r.persian_day   = 5'(pd);
            return r;
        endfunction

        function void note_date(g2p_pkg::greg_date_t g);
            awaited.push_back(to_persian(g));
        endfunction

        function void check_result(g2p_pkg::persian_date_t got);
            g2p_pkg::persian_date_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d", $time,
                         got.persian_year, got.persian_month, got.persian_day);
                return;
            end
            want = awaited.pop_front();
            if (got.persian_year !== want.persian_year || got.persian_month !== want.persian_month
                || got.persian_day !== want.persian_day)
            begin
                errors++;
                $display("%0t: date mismatch, expected %0d-%0d-%0d, actual %0d-%0d-%0d", $time,
                         want.persian_year, want.persian_month, want.persian_day,
                         got.persian_year, got.persian_month, got.persian_day);
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   greg_valid    = 1'b0;
    logic                   greg_ready;
    g2p_pkg::greg_date_t    greg_date     = '0;
    logic                   persian_valid;
    logic                   persian_ready = 1'b0;
    g2p_pkg::persian_date_t persian_date;

    bit             long_hold_req = 1'b0;
    bit             quiet         = 1'b0;
    date_scoreboard sb            = new();

    gregorian_to_persian_date_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .greg_valid    (greg_valid),
        .greg_ready    (greg_ready),
        .greg_date     (greg_date),
        .persian_valid (persian_valid),
        .persian_ready (persian_ready),
        .persian_date  (persian_date)
    );

    always #CLK_HALF clk = ~clk;

    // Both monitors sample at the edge, so they see the values the transaction was made with.
    always @(posedge clk)
    begin
        if (rst_n && greg_valid && greg_ready)
            sb.note_date(greg_date);
        if (rst_n && persian_valid && persian_ready)
            sb.check_result(persian_date);
    end

    function automatic g2p_pkg::greg_date_t make_date(int y, int m, int d);
        g2p_pkg::greg_date_t g;
        g.greg_year  = 12'(y);
        g.greg_month = 4'(m);
        g.greg_day   = 5'(d);
        return g;
    endfunction

    // Offers one date and returns at the edge where the transaction takes place.
    task automatic send_date(g2p_pkg::greg_date_t g);
        greg_valid <= 1'b1;
        greg_date  <= g;
        do
            @(posedge clk);
        while (!greg_ready);
    endtask

    task automatic maybe_idle(bit allowed);
        if (allowed && $urandom_range(0, 3) == 0)
        begin
            greg_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    function automatic g2p_pkg::greg_date_t random_date();
        g2p_pkg::greg_date_t g;
        if ($urandom_range(0, 9) < 8)
            g = make_date($urandom_range(1000, 3000), $urandom_range(1, 12),
                          $urandom_range(1, 31));
        else
            g = make_date($urandom_range(0, 4095), $urandom_range(0, 15),
                          $urandom_range(0, 31));
        return g;
    endfunction

    // Receiver side: random stalls, one long hold-off on request, none at the end.
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                persian_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                persian_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                persian_ready <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end
    end

    initial
    begin
        g2p_pkg::greg_date_t directed[$];
        directed = '{
            make_date(1000, 1, 1),   make_date(3000, 12, 31), make_date(2000, 2, 29),
            make_date(2000, 3, 20),  make_date(2001, 3, 20),  make_date(2001, 3, 21),
            make_date(2002, 3, 21),  make_date(2003, 3, 21),  make_date(2024, 3, 19),
            make_date(2025, 3, 19),  make_date(2025, 3, 20),  make_date(2024, 9, 22),
            make_date(2024, 9, 23),  make_date(2023, 12, 31), make_date(2022, 2, 19),
            make_date(1999, 0, 17),  make_date(2004, 13, 5),  make_date(2001, 15, 31),
            make_date(2010, 6, 0),   make_date(0, 1, 1),      make_date(4095, 12, 31),
            make_date(621, 3, 21),   make_date(622, 1, 1)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            maybe_idle(1'b1);
            send_date(directed[i]);
        end

        for (int i = 0; i < RANDOM_DATES; i++)
        begin
            if (i == HOLD_AT)
                long_hold_req = 1'b1;
            if (i == QUIET_FROM)
                quiet = 1'b1;
            // While the receiver holds off the sender keeps offering, so the pipeline fills.
            maybe_idle(!quiet && !(i >= HOLD_AT && i < HOLD_AT + HOLD_BURST));
            send_date(random_date());
        end
        greg_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("** gregorian_to_persian_date_core: PASSED **");
        else
            $display("** gregorian_to_persian_date_core: FAILED **");
        $finish;
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("%0t: run limit reached with %0d results outstanding", $time, sb.pending());
        $display("** gregorian_to_persian_date_core: FAILED **");
        $finish;
    end

endmodule

### gregorian_to_persian_date_core.f
rtl/g2p_pkg.sv
rtl/g2p_year_fold.sv
rtl/g2p_month_split.sv
rtl/gregorian_to_persian_date_core.sv
rtl/g2p_checker.sv
tb/sv/tb_gregorian_to_persian_date_core.sv
